@@ rtl/core/smm_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the matrix square block.
package smm_pkg;

    // Matrix geometry and arithmetic widths
    localparam int MAX_SIZE = 64;
    localparam int IDX_W    = $clog2(MAX_SIZE);
    localparam int SIZE_W   = IDX_W + 1;
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
    localparam int ELEM_W   = 16;
    localparam int PROD_W   = 2 * ELEM_W;
    localparam int ACC_W    = 40;
    localparam int SIZE_RST = 64;

    // Stream payload widths
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 56;

    // Operation codes carried in the slave tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;         // write the incoming element
        logic start;        // latch query, clear accumulator and index
        logic issue;        // read one row/column pair, step the index
        logic result_load;  // move the sum into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic err;          // latched query is out of range
        logic k_last;       // current index is the last one of the row
        logic out_free;     // output register can take a result this cycle
    } stat_t;

endpackage

@@ rtl/core/smm_ctrl.sv @@
// Sequencer for load and query transfers of the matrix square block.
module smm_ctrl
    import smm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   s_tvalid,
    input  logic   s_op,
    input  stat_t  stat,
    output logic   s_tready,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;
    logic   drain_reg;
    logic   drain_next;

    // State and drain counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        drain_next = drain_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && (s_op == OP_QUERY))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (stat.err)
                begin
                    state_next = ST_RESULT;
                end
                else if (stat.k_last)
                begin
                    state_next = ST_DRAIN;
                    drain_next = 1'b0;
                end
            end
            ST_DRAIN:
            begin
                // read and multiply stages still in flight
                if (drain_reg)
                begin
                    state_next = ST_RESULT;
                end
                drain_next = 1'b1;
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready        = 1'b0;
        cmd.load        = 1'b0;
        cmd.start       = 1'b0;
        cmd.issue       = 1'b0;
        cmd.result_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.load  = s_tvalid && (s_op == OP_LOAD);
                cmd.start = s_tvalid && (s_op == OP_QUERY);
            end
            ST_RUN:
            begin
                cmd.issue = !stat.err;
            end
            ST_DRAIN:
            begin
            end
            ST_RESULT:
            begin
                cmd.result_load = stat.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ rtl/core/smm_dp.sv @@
// Matrix store, shared multiply-accumulate and output register of the matrix square block.
module smm_dp
    import smm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    input  logic                     cfg_we,
    input  logic [SIZE_W-1:0]        cfg_wdata,
    input  logic [IDX_W-1:0]         in_row,
    input  logic [IDX_W-1:0]         in_col,
    input  logic signed [ELEM_W-1:0] in_value,
    input  logic                     out_ready,
    output stat_t                    stat,
    output logic                     out_valid,
    output logic [IDX_W-1:0]         out_row,
    output logic [IDX_W-1:0]         out_col,
    output logic signed [ACC_W-1:0]  out_sum,
    output logic                     out_err
);

    logic [ELEM_W-1:0]        mem [0:DEPTH-1];

    logic [SIZE_W-1:0]        size_reg;
    logic [SIZE_W-1:0]        n_eff;
    logic                     q_err;

    logic [IDX_W-1:0]         row_reg;
    logic [IDX_W-1:0]         col_reg;
    logic [IDX_W-1:0]         last_reg;
    logic                     err_reg;
    logic [IDX_W-1:0]         k_reg;

    logic [ELEM_W-1:0]        rd_a_reg;
    logic [ELEM_W-1:0]        rd_b_reg;
    logic                     rd_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [IDX_W-1:0]         out_row_reg;
    logic [IDX_W-1:0]         out_col_reg;
    logic signed [ACC_W-1:0]  out_sum_reg;
    logic                     out_err_reg;

    // Size register, values above the store size act as the store size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_W'(SIZE_RST);
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_wdata;
        end
    end

    assign n_eff = (size_reg > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : size_reg;
    assign q_err = ({1'b0, in_row} >= n_eff) || ({1'b0, in_col} >= n_eff);

    // Query context and index counter
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            row_reg  <= in_row;
            col_reg  <= in_col;
            err_reg  <= q_err;
            last_reg <= IDX_W'(n_eff - SIZE_W'(1));
            k_reg    <= '0;
        end
        else if (cmd.issue)
        begin
            k_reg <= k_reg + IDX_W'(1);
        end
    end

    // Matrix store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem[{in_row, in_col}] <= in_value;
        end
        if (cmd.issue)
        begin
            rd_a_reg <= mem[{row_reg, k_reg}];
            rd_b_reg <= mem[{k_reg, col_reg}];
        end
    end

    // Multiply stage
    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(rd_a_reg) * $signed(rd_b_reg);
    end

    // Accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= cmd.issue;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            out_row_reg <= row_reg;
            out_col_reg <= col_reg;
            out_sum_reg <= acc_reg;
            out_err_reg <= err_reg;
        end
    end

    assign stat.err      = err_reg;
    assign stat.k_last   = (k_reg == last_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_sum   = out_sum_reg;
    assign out_err   = out_err_reg;

endmodule

@@ rtl/core/square_matrix_multiply.sv @@
// Top level of the matrix square block: one product element per query transfer.
//
//  channel   direction  contents
//  s_*       in         tdata {value, col, row}, tuser opcode (load / query)
//  m_*       out        tdata {sum, col, row}, tuser index error
//  cfg_*     in         matrix_size write, no read-back
//
//  For matrix size n (up to 64), a query lets the single shared multiply-accumulate
//  walk the row and column once, one store read pair per cycle, through the read,
//  multiply and accumulate stages.
//  A query out of range returns a zero sum.
//  Reset is asynchronous, active low; the matrix store is not cleared.
//  A result waits in the output register; loads are still taken meanwhile,
//  a new query finishes and then holds until the output transfer is taken.
module square_matrix_multiply
    import smm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // row_index[5:0], col_index[11:6], element_value[27:12]
    input  logic [0:0]          s_tuser,   // opcode[0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // out_row[5:0], out_col[11:6], product_sum[51:12]
    output logic [0:0]          m_tuser,   // index_error[0]
    input  logic                cfg_we,
    input  logic [SIZE_W-1:0]   cfg_wdata  // matrix_size
);

    cmd_t                    cmd;
    stat_t                   stat;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [ACC_W-1:0] out_sum;
    logic                    out_err;

    smm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser[0]),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    smm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_row    (s_tdata[IDX_W-1:0]),
        .in_col    (s_tdata[2*IDX_W-1:IDX_W]),
        .in_value  (s_tdata[2*IDX_W+ELEM_W-1:2*IDX_W]),
        .out_ready (m_tready),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_sum   (out_sum),
        .out_err   (out_err)
    );

    // Output packing
    assign m_tdata = {(M_DATA_W - 2*IDX_W - ACC_W)'(0), out_sum, out_col, out_row};
    assign m_tuser = out_err;

    // An error result always carries a zero sum
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[2*IDX_W+ACC_W-1:2*IDX_W] == '0)
        else $error("error result with nonzero sum");

    // A query transfer blocks further input until its result is formed
    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == OP_QUERY) |=> !s_tready)
        else $error("input taken during query");

    // Loading a result always shows it on the output
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |=> m_tvalid)
        else $error("result lost");

    // Reads are never issued while idle or loading
    a_no_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !cmd.issue && !cmd.result_load)
        else $error("datapath active while idle");

endmodule
